/* src/bhcp_pkg.sv */
// shared types and constants of the bounded hop cheapest path block
package bhcp_pkg;
	localparam int MaxNodes = 128;
	localparam int MaxEdges = 8192;
	localparam int CostBits = 24;
	localparam int NodeBits = $clog2(MaxNodes);
	localparam int EdgeBits = $clog2(MaxEdges);
	localparam int PriceBits = 16;
	localparam int OutCostBits = 24;
	localparam logic [CostBits-1:0] CostTop = {CostBits{1'b1}};

	localparam logic [1:0] RegNodeCount = 2'd0;
	localparam logic [1:0] RegSource = 2'd1;
	localparam logic [1:0] RegTarget = 2'd2;
	localparam logic [1:0] RegMaxStops = 2'd3;

	typedef struct packed {
		logic [NodeBits-1:0] from;
		logic [NodeBits-1:0] to;
		logic [PriceBits-1:0] price;
	} edge_t;

	typedef struct packed {
		logic store;
		logic init;
		logic relax;
		logic copy;
		logic report;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic node_last;
		logic edge_last;
		logic round_last;
		logic no_edges;
		logic bad_ends;
	} sts_t;
endpackage

/* src/bhcp_datapath.sv */
// edge store, distance tables and relaxation unit
module bhcp_datapath import bhcp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	output sts_t sts,
	input  edge_t in_edge,
	input  logic [8:0] nodes,
	input  logic [NodeBits-1:0] src,
	input  logic [NodeBits-1:0] dst,
	input  logic [6:0] stops,
	output logic res_found,
	output logic [OutCostBits-1:0] res_cost
);
	logic [PriceBits+2*NodeBits-1:0] edge_mem [MaxEdges];
	logic [EdgeBits:0] total_q;
	logic [EdgeBits:0] rd_q;
	logic [NodeBits:0] node_q;
	logic [7:0] round_q;
	edge_t rd_s1;
	logic rd_vld_s1;
	logic [CostBits:0] prev_mem [MaxNodes];
	logic [CostBits:0] next_mem [MaxNodes];
	logic [CostBits:0] pf_s2, nt_s2;
	edge_t e_s2;
	logic vld_s2;
	logic [CostBits:0] sum;
	logic [CostBits-1:0] cand;
	logic relax_we;
	logic [CostBits:0] cp_s1;
	logic [NodeBits-1:0] cp_idx_s1;
	logic cp_vld_s1;
	logic [CostBits:0] tgt_q;
	logic tgt_found;
	logic found_q;
	logic [OutCostBits-1:0] cost_q;

	always_ff @(posedge clk) begin
		if (cmd.store && !total_q[EdgeBits])
			edge_mem[total_q[EdgeBits-1:0]] <= in_edge;
		rd_s1 <= edge_mem[rd_q[EdgeBits-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			rd_q <= '0;
			node_q <= '0;
			round_q <= '0;
			rd_vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			cp_vld_s1 <= 1'b0;
			found_q <= 1'b0;
			cost_q <= '0;
		end else begin
			if (cmd.clear)
				total_q <= '0;
			else if (cmd.store && !total_q[EdgeBits])
				total_q <= total_q + 1'b1;
			rd_vld_s1 <= cmd.relax;
			vld_s2 <= rd_vld_s1;
			cp_vld_s1 <= cmd.copy;
			if (cmd.relax)
				rd_q <= rd_q + 1'b1;
			else
				rd_q <= '0;
			if (cmd.init || cmd.copy)
				node_q <= node_q + 1'b1;
			else
				node_q <= '0;
			if (cmd.init)
				round_q <= '0;
			else if (cmd.copy && sts.node_last)
				round_q <= round_q + 1'b1;
			if (cmd.report) begin
				found_q <= tgt_found;
				cost_q <= tgt_found ? tgt_q[OutCostBits-1:0] : '0;
			end
		end
	end

	assign sts.edge_last = (rd_q + 1'b1) >= total_q;
	assign sts.no_edges = (total_q == '0);
	assign sts.node_last = node_q[NodeBits-1:0] == {NodeBits{1'b1}};
	assign sts.round_last = round_q == {1'b0, stops};
	assign sts.bad_ends = ({2'b0, src} >= nodes) || ({2'b0, dst} >= nodes);

	// read of previous table and next table for the edge in flight, and of the next table entry to copy
	always_ff @(posedge clk) begin
		e_s2 <= rd_s1;
		pf_s2 <= prev_mem[rd_s1.from];
		if (relax_we && e_s2.to == rd_s1.to)
			nt_s2 <= {1'b1, cand};
		else
			nt_s2 <= next_mem[rd_s1.to];
		cp_s1 <= next_mem[node_q[NodeBits-1:0]];
		cp_idx_s1 <= node_q[NodeBits-1:0];
	end

	assign sum = {1'b0, pf_s2[CostBits-1:0]} + {{(CostBits+1-PriceBits){1'b0}}, e_s2.price};
	assign cand = sum[CostBits] ? CostTop : sum[CostBits-1:0];
	assign relax_we = vld_s2 && pf_s2[CostBits] && ({2'b0, e_s2.from} < nodes)
		&& ({2'b0, e_s2.to} < nodes)
		&& (!nt_s2[CostBits] || cand < nt_s2[CostBits-1:0]);

	// bit CostBits of an entry is the reached flag
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			prev_mem[node_q[NodeBits-1:0]] <= (node_q[NodeBits-1:0] == src) ?
				{1'b1, {CostBits{1'b0}}} : '0;
			next_mem[node_q[NodeBits-1:0]] <= (node_q[NodeBits-1:0] == src) ?
				{1'b1, {CostBits{1'b0}}} : '0;
		end else begin
			if (cp_vld_s1)
				prev_mem[cp_idx_s1] <= cp_s1;
			if (relax_we)
				next_mem[e_s2.to] <= {1'b1, cand};
		end
		if (cp_vld_s1 && cp_idx_s1 == dst)
			tgt_q <= cp_s1;
		else
			tgt_q <= prev_mem[dst];
	end

	assign tgt_found = !sts.bad_ends && tgt_q[CostBits];
	assign res_found = found_q;
	assign res_cost = cost_q;
endmodule

/* src/bhcp_ctrl.sv */
// sequencer of load, relaxation rounds and result
module bhcp_ctrl import bhcp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic in_last,
	input  logic out_fire,
	input  sts_t sts,
	output cmd_t cmd,
	output logic in_ready,
	output logic out_valid
);
	typedef enum logic [6:0] {
		S_LOAD = 7'b0000001, S_INIT = 7'b0000010, S_RELAX = 7'b0000100,
		S_DRAIN = 7'b0001000, S_COPY = 7'b0010000, S_TGT = 7'b0100000,
		S_OUT = 7'b1000000
	} state_t;
	state_t state_q;
	logic [1:0] drain_q;
	logic out_valid_q;
	logic res_load;

	// result moves into the output register once that register is free
	assign res_load = state_q == S_OUT && (!out_valid_q || out_fire);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			drain_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load)
				out_valid_q <= 1'b1;
			else if (out_fire)
				out_valid_q <= 1'b0;
			case (state_q)
			S_LOAD: if (in_fire && in_last)
				state_q <= sts.bad_ends ? S_TGT : S_INIT;
			S_INIT: if (sts.node_last)
				state_q <= S_RELAX;
			S_RELAX: begin
				drain_q <= '0;
				if (sts.edge_last)
					state_q <= S_DRAIN;
			end
			S_DRAIN: begin
				drain_q <= drain_q + 1'b1;
				if (drain_q == 2'd2)
					state_q <= S_COPY;
			end
			S_COPY: if (sts.node_last)
				state_q <= sts.round_last ? S_TGT : S_RELAX;
			S_TGT: state_q <= S_OUT;
			S_OUT: if (res_load)
				state_q <= S_LOAD;
			default: state_q <= S_LOAD;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.store = in_fire;
		cmd.init = state_q == S_INIT;
		cmd.relax = state_q == S_RELAX && !sts.no_edges;
		cmd.copy = state_q == S_COPY;
		cmd.clear = res_load;
		cmd.report = res_load;
	end
	assign in_ready = state_q == S_LOAD;
	assign out_valid = out_valid_q;
endmodule

/* src/bounded_hop_cheapest_path.sv */
// Cheapest path over at most max_stops+1 edges. Edges load one word per cycle while
// s_tready is high into an 8192-entry store; the last edge starts the search and
// s_tready stays low until it ends: a table init over all 128 entries, then for each
// of max_stops+1 rounds a relaxation pass over the stored edges through the single
// edge memory read port, a drain and a copy of all 128 table entries, then the result
// goes to the output register. When source or target lies outside the graph, the search
// goes straight to the result. A result waiting on m holds back the next search's result.
module bounded_hop_cheapest_path import bhcp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [31:0] s_tdata, // edge_from, edge_to, edge_price, zero fill
	input  logic s_tlast, // last_edge
	output logic m_tvalid,
	input  logic m_tready,
	output logic [31:0] m_tdata, // found, cheapest_cost, zero fill
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	logic [7:0] node_count_q;
	logic [NodeBits-1:0] source_q, target_q;
	logic [6:0] stops_q;
	logic [8:0] nodes;
	cmd_t cmd;
	sts_t sts;
	logic found;
	logic [OutCostBits-1:0] cost;
	edge_t in_edge;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 8'd1;
			source_q <= '0;
			target_q <= '0;
			stops_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
			RegNodeCount: node_count_q <= cfg_data;
			RegSource: source_q <= cfg_data[NodeBits-1:0];
			RegTarget: target_q <= cfg_data[NodeBits-1:0];
			RegMaxStops: stops_q <= cfg_data[6:0];
			default: ;
			endcase
		end
	end
	assign nodes = (node_count_q > 8'd128) ? 9'd128 : {1'b0, node_count_q};
	assign in_edge = '{from: s_tdata[6:0], to: s_tdata[13:7], price: s_tdata[29:14]};

	bhcp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(s_tvalid && s_tready), .in_last(s_tlast),
		.out_fire(m_tvalid && m_tready), .sts(sts), .cmd(cmd),
		.in_ready(s_tready), .out_valid(m_tvalid)
	);
	bhcp_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .in_edge(in_edge),
		.nodes(nodes), .src(source_q), .dst(target_q), .stops(stops_q),
		.res_found(found), .res_cost(cost)
	);
	assign m_tdata = {7'd0, cost, found};
endmodule

/* tb/sv/bhcp_checker.sv */
// checker for the bounded hop cheapest path block: predicts each search result and compares
module bhcp_checker import bhcp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tready,
	input  logic [31:0] s_tdata,
	input  logic s_tlast,
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [31:0] m_tdata,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output int fail_count,
	output int pending,
	output int results_checked,
	output int edges_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic found;
		logic [OutCostBits-1:0] cost;
	} answer_t;

	logic [7:0] node_count;
	logic [NodeBits-1:0] source_node;
	logic [NodeBits-1:0] target_node;
	logic [NodeBits-1:0] max_stops;

	edge_t graph_edges[$];
	answer_t pending_answers[$];
	longint dist_prev[MaxNodes];
	longint dist_next[MaxNodes];
	bit reach_prev[MaxNodes];
	bit reach_next[MaxNodes];

	function automatic answer_t cheapest_within_hops();
		int nodes;
		int rounds;
		int f;
		int t;
		longint cand;
		answer_t ans;
		ans = '0;
		nodes = (node_count > MaxNodes) ? MaxNodes : node_count;
		rounds = max_stops + 1;
		if (source_node >= nodes || target_node >= nodes)
			return ans;
		for (int n = 0; n < MaxNodes; n++) begin
			dist_prev[n] = 0;
			reach_prev[n] = 0;
		end
		reach_prev[source_node] = 1;
		for (int r = 0; r < rounds; r++) begin
			dist_next = dist_prev;
			reach_next = reach_prev;
			foreach (graph_edges[i]) begin
				f = graph_edges[i].from;
				t = graph_edges[i].to;
				if (f < nodes && t < nodes && reach_prev[f]) begin
					cand = dist_prev[f] + graph_edges[i].price;
					if (cand > longint'(CostTop))
						cand = longint'(CostTop);
					if (!reach_next[t] || cand < dist_next[t]) begin
						dist_next[t] = cand;
						reach_next[t] = 1;
					end
				end
			end
			dist_prev = dist_next;
			reach_prev = reach_next;
		end
		if (reach_prev[target_node]) begin
			ans.found = 1'b1;
			ans.cost = (dist_prev[target_node] > 64'd16777215) ? 24'hFFFFFF :
				dist_prev[target_node][OutCostBits-1:0];
		end
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t got;
		answer_t want;
		edge_t e;
		if (!arst_n) begin
			node_count <= 8'd1;
			source_node <= '0;
			target_node <= '0;
			max_stops <= '0;
			graph_edges.delete();
			pending_answers.delete();
			fail_count <= 0;
			pending <= 0;
			results_checked <= 0;
			edges_seen <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				edges_seen <= edges_seen + 1;
				e.from = s_tdata[6:0];
				e.to = s_tdata[13:7];
				e.price = s_tdata[29:14];
				if (graph_edges.size() < MaxEdges)
					graph_edges.insert(graph_edges.size(), e);
				if (s_tlast) begin
					pending_answers.insert(pending_answers.size(), cheapest_within_hops());
					graph_edges.delete();
				end
			end
			if (m_tvalid && m_tready) begin
				got.found = m_tdata[0];
				got.cost = m_tdata[24:1];
				results_checked <= results_checked + 1;
				if (pending_answers.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result word: found %0d cost %0d",
							got.found, got.cost);
					fail_count <= fail_count + 1;
				end else begin
					want = pending_answers.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("mismatch: expected found %0d cost %0d, got found %0d cost %0d",
								want.found, want.cost, got.found, got.cost);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					RegNodeCount: node_count <= cfg_data;
					RegSource: source_node <= cfg_data[6:0];
					RegTarget: target_node <= cfg_data[6:0];
					RegMaxStops: max_stops <= cfg_data[6:0];
					default: ;
				endcase
			end
			pending <= pending_answers.size();
		end
	end
endmodule

/* tb/sv/tb_bounded_hop_cheapest_path.sv */
// testbench top for the bounded hop cheapest path block: stimulus, stalls and verdict
module tb_bounded_hop_cheapest_path;
	import bhcp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [31:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [31:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	int fail_count;
	int pending;
	int results_checked;
	int edges_seen;
	int burst_left;
	int rx_left;
	int rx_mode;
	int graphs_sent;
	int cur_nodes;

	bounded_hop_cheapest_path u_dut (.*);

	bhcp_checker u_chk (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// receiver stall pattern
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_left = $urandom_range(1, 80);
			rx_mode = $urandom_range(0, 3);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			0: m_tready = 1'b1;
			1: m_tready = $urandom_range(0, 1);
			2: m_tready = ($urandom_range(0, 3) == 0);
			default: m_tready = ($urandom_range(0, 7) != 0);
		endcase
	end

	task automatic send_edge(input int from_n, input int to_n, input int price, input bit last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tdata = {2'b00, price[15:0], to_n[6:0], from_n[6:0]};
		s_tlast = last;
		s_tvalid = 1'b1;
		forever begin
			@(posedge clk);
			if (s_tready)
				break;
		end
		@(negedge clk);
		if (last)
			graphs_sent++;
	endtask

	task automatic settle();
		s_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int val);
		cfg_index = idx;
		cfg_data = val[7:0];
		cfg_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic configure(input int nc, input int src, input int tgt, input int stops);
		write_reg(RegNodeCount, nc);
		write_reg(RegSource, src);
		write_reg(RegTarget, tgt);
		write_reg(RegMaxStops, stops);
		cur_nodes = (nc > MaxNodes) ? MaxNodes : nc;
	endtask

	function automatic int pick_node();
		if (cur_nodes > 0 && $urandom_range(0, 9) != 0)
			return $urandom_range(0, cur_nodes - 1);
		return $urandom_range(0, 127);
	endfunction

	function automatic int pick_price();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 65535;
			2, 3, 4: return $urandom_range(0, 65535);
			default: return $urandom_range(0, 15);
		endcase
	endfunction

	initial begin
		int nc;
		int stops;
		int n_edges;
		int n_graphs;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = RegNodeCount;
		cfg_data = '0;
		burst_left = 0;
		rx_left = 0;
		rx_mode = 0;
		graphs_sent = 0;
		cur_nodes = 1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// single node, self loop, source equals target
		send_edge(0, 0, 0, 1);
		settle();
		configure(128, 0, 127, 1);
		send_edge(0, 127, 65535, 0);
		send_edge(0, 64, 1, 0);
		send_edge(127, 0, 0, 0);
		send_edge(64, 127, 2, 1);
		settle();
		write_reg(RegMaxStops, 0);
		send_edge(0, 127, 65535, 0);
		send_edge(0, 64, 1, 0);
		send_edge(64, 127, 2, 1);
		settle();
		configure(0, 0, 0, 127);
		send_edge(0, 0, 5, 1);
		settle();
		configure(255, 0, 127, 127);
		send_edge(0, 127, 7, 1);
		settle();
		configure(4, 5, 1, 2);
		send_edge(5, 1, 1, 1);
		settle();
		configure(4, 0, 3, 2);
		send_edge(0, 5, 1, 0);
		send_edge(0, 3, 9, 0);
		send_edge(0, 3, 4, 0);
		send_edge(3, 3, 0, 1);
		settle();
		write_reg(RegTarget, 2);
		send_edge(0, 3, 9, 0);
		send_edge(3, 3, 0, 1);
		settle();

		while (edges_seen < 1580) begin
			case ($urandom_range(0, 19))
				0: nc = 0;
				1: nc = 1;
				2, 3: nc = 128;
				4: nc = $urandom_range(129, 255);
				default: nc = $urandom_range(2, 16);
			endcase
			case ($urandom_range(0, 9))
				0: stops = 127;
				1, 2: stops = $urandom_range(5, 20);
				default: stops = $urandom_range(0, 4);
			endcase
			cur_nodes = (nc > MaxNodes) ? MaxNodes : nc;
			configure(nc, pick_node(), pick_node(), stops);
			n_graphs = $urandom_range(3, 8);
			for (int g = 0; g < n_graphs; g++) begin
				n_edges = (stops > 20) ? $urandom_range(1, 4) : $urandom_range(1, 12);
				for (int k = 0; k < n_edges; k++)
					send_edge(pick_node(), pick_node(), pick_price(), k == n_edges - 1);
				if ($urandom_range(0, 9) == 0) begin
					s_tvalid = 1'b0;
					while (pending != 0)
						@(negedge clk);
				end
			end
			settle();
		end

		settle();
		repeat (200) @(negedge clk);
		$display("sent %0d edges in %0d graphs, checked %0d result words",
			edges_seen, graphs_sent, results_checked);
		$display("covered self loops, parallel edges, out of range nodes and counts, hop limits 0 to 127");
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#1_500_000_000;
		$display("timeout with %0d results outstanding", pending);
		$display("CHECKS FAILED");
		$finish;
	end
endmodule

/* filelist.f */
src/bhcp_pkg.sv
src/bhcp_datapath.sv
src/bhcp_ctrl.sv
src/bounded_hop_cheapest_path.sv
tb/sv/bhcp_checker.sv
tb/sv/tb_bounded_hop_cheapest_path.sv
